// ===== design/ssre_pkg.sv =====
package ssre_pkg;

    localparam int NUM_OBJECTS_DEF = 128;
    localparam int MAX_HITS_DEF    = 32;

    localparam int IDX_W   = 7;
    localparam int X_W     = 9;
    localparam int Y_W     = 8;
    localparam int DIM_W   = 7;
    localparam int SEL_W   = 3;
    localparam int LIM_W   = 6;
    localparam int CNT_W   = 6;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 32;

    localparam logic [X_W-1:0] X_WRAP_EDGE = 9'h100;
    localparam logic [SEL_W-1:0] SIZE_SELECT_RST = 3'd0;
    localparam logic [LIM_W-1:0] MAX_PER_LINE_RST = 6'd32;

    localparam logic REG_SIZE_SELECT  = 1'b0;
    localparam logic REG_MAX_PER_LINE = 1'b1;

    localparam logic REQ_WRITE    = 1'b0;
    localparam logic REQ_EVALUATE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic           is_large;
        logic [Y_W-1:0] y;
        logic [X_W-1:0] x;
    } obj_entry_t;

    function automatic logic [DIM_W-1:0] obj_width(input logic [SEL_W-1:0] sel,
                                                  input logic lg);
        logic [DIM_W-1:0] w;
        case ({sel, lg})
            4'b000_0: w = 7'd8;
            4'b000_1: w = 7'd16;
            4'b001_0: w = 7'd8;
            4'b001_1: w = 7'd32;
            4'b010_0: w = 7'd8;
            4'b010_1: w = 7'd64;
            4'b011_0: w = 7'd16;
            4'b011_1: w = 7'd32;
            4'b100_0: w = 7'd16;
            4'b100_1: w = 7'd64;
            4'b101_0: w = 7'd32;
            4'b101_1: w = 7'd64;
            4'b110_0: w = 7'd16;
            4'b110_1: w = 7'd32;
            4'b111_0: w = 7'd16;
            4'b111_1: w = 7'd32;
            default:  w = 7'd8;
        endcase
        return w;
    endfunction

    function automatic logic [DIM_W-1:0] obj_height(input logic [SEL_W-1:0] sel,
                                                   input logic lg);
        logic [DIM_W-1:0] h;
        case ({sel, lg})
            4'b000_0: h = 7'd8;
            4'b000_1: h = 7'd16;
            4'b001_0: h = 7'd8;
            4'b001_1: h = 7'd32;
            4'b010_0: h = 7'd8;
            4'b010_1: h = 7'd64;
            4'b011_0: h = 7'd16;
            4'b011_1: h = 7'd32;
            4'b100_0: h = 7'd16;
            4'b100_1: h = 7'd64;
            4'b101_0: h = 7'd32;
            4'b101_1: h = 7'd64;
            4'b110_0: h = 7'd32;
            4'b110_1: h = 7'd64;
            4'b111_0: h = 7'd32;
            4'b111_1: h = 7'd32;
            default:  h = 7'd8;
        endcase
        return h;
    endfunction

endpackage

// ===== design/ssre_ram.sv =====
module ssre_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/scanline_sprite_range_evaluator_top.sv =====
// Object range evaluator for one scanline. A write word (tuser 0) stores one object of the
// 128-entry table and produces no result. An evaluate word (tuser 1) walks NUM_OBJECTS
// entries from start_index, one entry per cycle unless the result side stalls, through the
// single read port of the object RAM, and sends one word per object in range, up to the
// configured limit, with tlast on the final one; an empty scan sends one word with found
// (tuser) low. An evaluation ends early when the limit is reached, and s_tready stays low
// throughout. The table reads as all zero after reset through per-entry valid flags, so no
// clearing pass is needed.
module scanline_sprite_range_evaluator_top
    import ssre_pkg::*;
#(
    parameter int NUM_OBJECTS = NUM_OBJECTS_DEF,
    parameter int MAX_HITS    = MAX_HITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_tvalid,
    output logic              s_tready,
    // obj_index[6:0], x_pos[15:7], y_pos[23:16], large_req[24], line[32:25],
    // start_index[39:33]
    input  logic [39:0]       s_tdata,
    // req_type[0]
    input  logic              s_tuser,

    output logic              m_tvalid,
    input  logic              m_tready,
    // hit_index[6:0], hit_count[12:7], zero[15:13]
    output logic [15:0]       m_tdata,
    // found[0]
    output logic              m_tuser,
    output logic              m_tlast,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    localparam int AW = $clog2(NUM_OBJECTS);
    localparam int IW = $clog2(NUM_OBJECTS + 1);
    localparam int HW = $clog2(MAX_HITS + 1);
    localparam int EW = $bits(obj_entry_t);

    state_t state_reg, state_next;

    logic [SEL_W-1:0] size_select_reg;
    logic [LIM_W-1:0] max_per_line_reg;

    logic [NUM_OBJECTS-1:0] valid_reg;

    logic [Y_W-1:0]   line_reg, line_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IW-1:0]    iss_reg, iss_next;
    logic [HW-1:0]    hits_reg, hits_next;
    logic [HW-1:0]    limit_reg, limit_next;

    logic             rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_last_reg;
    logic             rd_inrange_reg;
    logic             vbit_reg;

    logic             pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0] pend_index_reg, pend_index_next;
    logic [CNT_W-1:0] pend_count_reg, pend_count_next;

    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] out_index_reg, out_index_next;
    logic [CNT_W-1:0] out_count_reg, out_count_next;
    logic             out_found_reg, out_found_next;
    logic             out_last_reg, out_last_next;

    logic [IDX_W-1:0] in_obj_index, in_start_index;
    logic [X_W-1:0]   in_x_pos;
    logic [Y_W-1:0]   in_y_pos, in_line;
    logic             in_large_req;

    logic             in_accept, wr_accept, ev_accept;
    logic             ram_we, rd_en, advance, stall;
    logic [EW-1:0]    ram_rdata;
    obj_entry_t       wr_entry, ent;
    logic [DIM_W-1:0] obj_h, obj_w;
    logic [Y_W-1:0]   dy;
    logic [X_W-1:0]   x_neg;
    logic             y_ok, x_ok, hit, final_hit, out_free;
    logic [HW-1:0]    count_new;
    logic [LIM_W:0]   mpl_ext, lim_ext;
    logic             cfg_wr;

    assign in_obj_index   = s_tdata[6:0];
    assign in_x_pos       = s_tdata[15:7];
    assign in_y_pos       = s_tdata[23:16];
    assign in_large_req   = s_tdata[24];
    assign in_line        = s_tdata[32:25];
    assign in_start_index = s_tdata[39:33];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign wr_accept = in_accept && (s_tuser == REQ_WRITE);
    assign ev_accept = in_accept && (s_tuser == REQ_EVALUATE);
    assign ram_we    = wr_accept && ({1'b0, in_obj_index} < (IDX_W + 1)'(NUM_OBJECTS));

    assign wr_entry.x        = in_x_pos;
    assign wr_entry.y        = in_y_pos + 1'b1;
    assign wr_entry.is_large = in_large_req;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            REG_SIZE_SELECT:  prdata = CFG_DW'(size_select_reg);
            REG_MAX_PER_LINE: prdata = CFG_DW'(max_per_line_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_select_reg  <= SIZE_SELECT_RST;
            max_per_line_reg <= MAX_PER_LINE_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_SIZE_SELECT:  size_select_reg  <= pwdata[SEL_W-1:0];
                REG_MAX_PER_LINE: max_per_line_reg <= pwdata[LIM_W-1:0];
                default:          size_select_reg  <= size_select_reg;
            endcase
        end
    end

    ssre_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_OBJECTS)
    ) u_obj_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (in_obj_index[AW-1:0]),
        .wdata (wr_entry),
        .re    (rd_en),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Range check on the registered entry from the last RAM read.
    assign ent       = vbit_reg ? obj_entry_t'(ram_rdata) : '0;
    assign obj_h     = obj_height(size_select_reg, ent.is_large);
    assign obj_w     = obj_width(size_select_reg, ent.is_large);
    assign dy        = line_reg - ent.y;
    assign y_ok      = dy < {1'b0, obj_h};
    assign x_neg     = X_W'(10'd512 - {1'b0, ent.x});
    assign x_ok      = (ent.x == X_WRAP_EDGE) || !ent.x[X_W-1] || (x_neg < {2'b00, obj_w});
    assign hit       = rd_inrange_reg && y_ok && x_ok;
    assign count_new = hits_reg + 1'b1;
    assign final_hit = (count_new == limit_reg);

    assign out_free = !out_valid_reg || m_tready;
    assign stall    = (state_reg == ST_SCAN) && rd_vld_reg && hit && pend_valid_reg && !out_free;
    assign advance  = !stall;
    assign rd_en    = (state_reg == ST_SCAN) && (iss_reg < IW'(NUM_OBJECTS)) && advance;

    assign mpl_ext = {1'b0, max_per_line_reg};
    assign lim_ext = (max_per_line_reg == '0) ? (LIM_W + 1)'(1) :
                     ((mpl_ext > (LIM_W + 1)'(MAX_HITS)) ? (LIM_W + 1)'(MAX_HITS) : mpl_ext);

    always_comb begin
        state_next      = state_reg;
        line_next       = line_reg;
        idx_next        = idx_reg;
        iss_next        = iss_reg;
        hits_next       = hits_reg;
        limit_next      = limit_reg;
        rd_vld_next     = advance ? rd_en : rd_vld_reg;
        pend_valid_next = pend_valid_reg;
        pend_index_next = pend_index_reg;
        pend_count_next = pend_count_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_index_next  = out_index_reg;
        out_count_next  = out_count_reg;
        out_found_next  = out_found_reg;
        out_last_next   = out_last_reg;

        if (rd_en) begin
            idx_next = idx_reg + 1'b1;
            iss_next = iss_reg + 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                rd_vld_next = 1'b0;
                if (ev_accept) begin
                    state_next      = ST_SCAN;
                    line_next       = in_line;
                    idx_next        = in_start_index;
                    iss_next        = '0;
                    hits_next       = '0;
                    limit_next      = HW'(lim_ext);
                    pend_valid_next = 1'b0;
                end
            end
            ST_SCAN: begin
                if (rd_vld_reg && !stall) begin
                    if (hit) begin
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_index_next = pend_index_reg;
                            out_count_next = pend_count_reg;
                            out_found_next = 1'b1;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_index_next = rd_idx_reg;
                        pend_count_next = CNT_W'(count_new);
                        hits_next       = count_new;
                        if (final_hit) begin
                            state_next = ST_DONE;
                        end
                    end
                    if (rd_last_reg) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                rd_vld_next = 1'b0;
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_index_next  = pend_valid_reg ? pend_index_reg : '0;
                    out_count_next  = pend_valid_reg ? pend_count_reg : '0;
                    out_found_next  = pend_valid_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            rd_vld_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            iss_reg        <= '0;
            hits_reg       <= '0;
            limit_reg      <= HW'(1);
        end else begin
            if (ram_we) begin
                valid_reg[in_obj_index[AW-1:0]] <= 1'b1;
            end
            rd_vld_reg     <= rd_vld_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            iss_reg        <= iss_next;
            hits_reg       <= hits_next;
            limit_reg      <= limit_next;
        end
    end

    always_ff @(posedge aclk) begin
        line_reg       <= line_next;
        idx_reg        <= idx_next;
        pend_index_reg <= pend_index_next;
        pend_count_reg <= pend_count_next;
        out_index_reg  <= out_index_next;
        out_count_reg  <= out_count_next;
        out_found_reg  <= out_found_next;
        out_last_reg   <= out_last_next;
        if (rd_en) begin
            rd_idx_reg     <= idx_reg;
            rd_last_reg    <= (iss_reg == IW'(NUM_OBJECTS - 1));
            rd_inrange_reg <= ({1'b0, idx_reg} < (IDX_W + 1)'(NUM_OBJECTS));
            vbit_reg       <= valid_reg[idx_reg[AW-1:0]];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_count_reg, out_index_reg};
    assign m_tuser  = out_found_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_hits_within_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (hits_reg <= limit_reg))
        else $error("hit count has passed the per-line limit");

    a_issue_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        iss_reg <= IW'(NUM_OBJECTS))
        else $error("more reads issued than table entries");

    a_pending_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (pend_count_reg != '0))
        else $error("held hit carries a zero count");

    a_empty_word_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_found_reg) |-> (out_last_reg && (out_count_reg == '0)))
        else $error("empty-scan word is malformed");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_index_reg)
            && $stable(out_last_reg)))
        else $error("output word overwritten while stalled");
`endif

endmodule
